>>> hw/rtl/p2r_pkg.sv
// Shared types and fixed constants of the PPM to BGR565 framebuffer writer.
`default_nettype none

package p2r_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DIM_W    = 12;
  localparam int unsigned STRIDE_W = 12;
  localparam int unsigned ADDR_W   = 24;
  localparam int unsigned PIX_W    = 16;
  localparam int unsigned ACC_W    = 16;

  // Saturation bound for parsed width and height
  localparam logic [DIM_W-1:0] DIM_MAX = 12'd4095;

  // Row stride after reset
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 12'd1600;

  // Header characters
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;

  // Result status codes
  typedef enum logic [1:0] {
    ST_WRITE      = 2'd0,
    ST_WRITE_DONE = 2'd1,
    ST_DONE       = 2'd2,
    ST_ERROR      = 2'd3
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/ppm_to_rgb565_framebuffer.sv
// Streaming binary PPM parser that turns RGB888 pixels into BGR565 framebuffer writes.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------------
//   in      | input     | in_valid/in_ready  | in_data_byte
//   out     | output    | out_valid/out_ready| out_status, out_write_address, out_pixel_value
//   cfg     | input     | cfg_we             | cfg_row_stride_bytes
//
// One byte is taken per cycle while in_ready is high; a byte passes an input register and
// then the parse and address logic into the result register.
// The address path (one 13x12 multiply and an add) sets the cycle time.
// rst_n is synchronous, active low, and returns the parser to header line one.
// A stalled result holds in the output register while one more byte waits in the
// input register; in_ready drops only when both are full and out_ready is low.
`default_nettype none

module ppm_to_rgb565_framebuffer #(
  parameter int unsigned ROWS_PER_CHUNK = 4,
  parameter int unsigned CHUNK_PIXELS   = 640,
  parameter int unsigned MAX_LINE       = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [p2r_pkg::BYTE_W-1:0]    in_data_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_status,
  output logic [p2r_pkg::ADDR_W-1:0]         out_write_address,
  output logic [p2r_pkg::PIX_W-1:0]          out_pixel_value,
  input  wire logic                          cfg_we,
  input  wire logic [p2r_pkg::STRIDE_W-1:0]  cfg_row_stride_bytes
);

  localparam int unsigned CHUNK_BYTES = 3 * ROWS_PER_CHUNK * CHUNK_PIXELS;
  localparam int unsigned LC_W  = $clog2(MAX_LINE + 1);
  localparam int unsigned COL_W = $clog2(CHUNK_PIXELS + 1);
  localparam int unsigned RIC_W = $clog2(ROWS_PER_CHUNK + 1);
  localparam int unsigned OFF_W = $clog2(CHUNK_BYTES + 1);
  localparam int unsigned ROW_W = $clog2(4095 + 2 * ROWS_PER_CHUNK + 1);
  localparam int unsigned PROD_W = ROW_W + p2r_pkg::STRIDE_W;

  typedef enum logic [1:0] {
    PH_LINE1  = 2'd0,
    PH_SIZE   = 2'd1,
    PH_LINE3  = 2'd2,
    PH_PIXELS = 2'd3
  } phase_t;

  // Input register
  logic                         s1_valid_r;
  logic [p2r_pkg::BYTE_W-1:0]   s1_byte_r;
  logic                         s1_go;

  // Parser state
  phase_t                       phase_r, phase_nxt;
  logic [LC_W-1:0]              line_count_r, line_count_nxt;
  logic                         parsing_height_r, parsing_height_nxt;
  logic [p2r_pkg::DIM_W-1:0]    image_width_r, image_width_nxt;
  logic [p2r_pkg::DIM_W-1:0]    image_height_r, image_height_nxt;
  logic [OFF_W-1:0]             limit_r, limit_nxt;
  logic [ROW_W-1:0]             chunk_row_base_r, chunk_row_base_nxt;
  logic [RIC_W-1:0]             row_in_chunk_r, row_in_chunk_nxt;
  logic [COL_W-1:0]             column_r, column_nxt;
  logic [1:0]                   byte_of_pixel_r, byte_of_pixel_nxt;
  logic [OFF_W-1:0]             chunk_offset_r, chunk_offset_nxt;
  logic [p2r_pkg::BYTE_W-1:0]   red_hold_r, red_hold_nxt;
  logic [p2r_pkg::BYTE_W-1:0]   green_hold_r, green_hold_nxt;
  logic [p2r_pkg::STRIDE_W-1:0] stride_r;

  // Result register
  logic                         out_valid_r, out_valid_nxt;
  p2r_pkg::status_t             status_r, status_nxt;
  logic [p2r_pkg::ADDR_W-1:0]   addr_r, addr_nxt;
  logic [p2r_pkg::PIX_W-1:0]    pix_r, pix_nxt;

  // Datapath helpers
  logic                         emit;
  logic                         wrote;
  logic [LC_W-1:0]              lc_inc;
  logic [3:0]                   digit;
  logic [p2r_pkg::DIM_W-1:0]    dim_cur;
  logic [p2r_pkg::ACC_W-1:0]    dim_acc;
  logic [p2r_pkg::DIM_W-1:0]    dim_sat;
  logic [COL_W-1:0]             col_inc;
  logic [OFF_W-1:0]             off_inc;
  logic [ROW_W-1:0]             row_idx;
  logic [ROW_W-1:0]             base_inc;
  logic [PROD_W-1:0]            row_prod;
  logic [p2r_pkg::ADDR_W-1:0]   pix_addr;
  logic [p2r_pkg::PIX_W-1:0]    pix_bgr;

  // Handshake: advance the input item whenever the result register can take it
  assign s1_go     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_go;
  assign out_valid = out_valid_r;
  assign out_status        = status_r;
  assign out_write_address = addr_r;
  assign out_pixel_value   = pix_r;

  // Decimal accumulate with saturation for the size line
  assign digit   = s1_byte_r[3:0];
  assign dim_cur = parsing_height_r ? image_height_r : image_width_r;
  assign dim_acc = (p2r_pkg::ACC_W'(dim_cur) << 3) + (p2r_pkg::ACC_W'(dim_cur) << 1)
                   + p2r_pkg::ACC_W'(digit);
  assign dim_sat = (dim_acc > p2r_pkg::ACC_W'(p2r_pkg::DIM_MAX)) ? p2r_pkg::DIM_MAX
                                                                  : dim_acc[p2r_pkg::DIM_W-1:0];

  // Pixel address and color packing
  assign lc_inc   = line_count_r + LC_W'(1);
  assign col_inc  = column_r + COL_W'(1);
  assign off_inc  = chunk_offset_r + OFF_W'(1);
  assign row_idx  = chunk_row_base_r + ROW_W'(row_in_chunk_r);
  assign base_inc = chunk_row_base_r + ROW_W'(ROWS_PER_CHUNK);
  assign row_prod = PROD_W'(row_idx) * PROD_W'(stride_r);
  assign pix_addr = p2r_pkg::ADDR_W'(row_prod) + (p2r_pkg::ADDR_W'(column_r) << 1);
  assign pix_bgr  = {s1_byte_r[7:3], green_hold_r[7:2], red_hold_r[7:3]};

  // Next-state logic for one item
  always_comb begin
    phase_nxt          = phase_r;
    line_count_nxt     = line_count_r;
    parsing_height_nxt = parsing_height_r;
    image_width_nxt    = image_width_r;
    image_height_nxt   = image_height_r;
    limit_nxt          = limit_r;
    chunk_row_base_nxt = chunk_row_base_r;
    row_in_chunk_nxt   = row_in_chunk_r;
    column_nxt         = column_r;
    byte_of_pixel_nxt  = byte_of_pixel_r;
    chunk_offset_nxt   = chunk_offset_r;
    red_hold_nxt       = red_hold_r;
    green_hold_nxt     = green_hold_r;
    emit               = 1'b0;
    wrote              = 1'b0;
    status_nxt         = p2r_pkg::ST_WRITE;
    addr_nxt           = '0;
    pix_nxt            = '0;

    if (phase_r == PH_PIXELS) begin
      // Take pixel bytes up to the used part of the chunk, drop the rest
      if (chunk_offset_r < limit_r) begin
        unique case (byte_of_pixel_r)
          2'd0: begin
            red_hold_nxt      = s1_byte_r;
            byte_of_pixel_nxt = 2'd1;
          end
          2'd1: begin
            green_hold_nxt    = s1_byte_r;
            byte_of_pixel_nxt = 2'd2;
          end
          default: begin
            wrote             = 1'b1;
            addr_nxt          = pix_addr;
            pix_nxt           = pix_bgr;
            byte_of_pixel_nxt = 2'd0;
            if (p2r_pkg::DIM_W'(col_inc) >= image_width_r) begin
              column_nxt       = '0;
              row_in_chunk_nxt = row_in_chunk_r + RIC_W'(1);
            end else begin
              column_nxt = col_inc;
            end
          end
        endcase
      end
      chunk_offset_nxt = off_inc;
      emit             = wrote;
      // Close the chunk and finish the image once the height is covered
      if (off_inc >= OFF_W'(CHUNK_BYTES)) begin
        chunk_offset_nxt   = '0;
        row_in_chunk_nxt   = '0;
        column_nxt         = '0;
        byte_of_pixel_nxt  = 2'd0;
        chunk_row_base_nxt = base_inc;
        if (base_inc >= ROW_W'(image_height_r)) begin
          phase_nxt          = PH_LINE1;
          line_count_nxt     = '0;
          parsing_height_nxt = 1'b0;
          chunk_row_base_nxt = '0;
          emit               = 1'b1;
          status_nxt         = wrote ? p2r_pkg::ST_WRITE_DONE : p2r_pkg::ST_DONE;
        end
      end
    end else if (s1_byte_r == p2r_pkg::CHAR_LF) begin
      // End of a header line
      line_count_nxt = '0;
      unique case (phase_r)
        PH_LINE1: begin
          phase_nxt          = PH_SIZE;
          parsing_height_nxt = 1'b0;
          image_width_nxt    = '0;
          image_height_nxt   = '0;
        end
        PH_SIZE: begin
          if (image_width_r > p2r_pkg::DIM_W'(CHUNK_PIXELS)) begin
            phase_nxt          = PH_LINE1;
            parsing_height_nxt = 1'b0;
            emit               = 1'b1;
            status_nxt         = p2r_pkg::ST_ERROR;
          end else begin
            phase_nxt = PH_LINE3;
            limit_nxt = OFF_W'(image_width_r) * OFF_W'(3 * ROWS_PER_CHUNK);
          end
        end
        default: begin
          if (image_height_r == '0) begin
            phase_nxt          = PH_LINE1;
            parsing_height_nxt = 1'b0;
            emit               = 1'b1;
            status_nxt         = p2r_pkg::ST_DONE;
          end else begin
            phase_nxt          = PH_PIXELS;
            chunk_row_base_nxt = '0;
            row_in_chunk_nxt   = '0;
            column_nxt         = '0;
            byte_of_pixel_nxt  = 2'd0;
            chunk_offset_nxt   = '0;
          end
        end
      endcase
    end else if (lc_inc >= LC_W'(MAX_LINE)) begin
      // Header line too long
      phase_nxt          = PH_LINE1;
      line_count_nxt     = '0;
      parsing_height_nxt = 1'b0;
      emit               = 1'b1;
      status_nxt         = p2r_pkg::ST_ERROR;
    end else begin
      line_count_nxt = lc_inc;
      // Parse width, then height after the first space
      if (phase_r == PH_SIZE && s1_byte_r != p2r_pkg::CHAR_CR) begin
        if (s1_byte_r == p2r_pkg::CHAR_SPACE && !parsing_height_r) begin
          parsing_height_nxt = 1'b1;
        end else if (s1_byte_r >= p2r_pkg::CHAR_0 && s1_byte_r <= p2r_pkg::CHAR_9) begin
          if (parsing_height_r) begin
            image_height_nxt = dim_sat;
          end else begin
            image_width_nxt = dim_sat;
          end
        end
      end
    end

    out_valid_nxt = s1_go ? emit : (out_valid_r && !out_ready);
  end

  // Hold state, input register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      s1_byte_r        <= '0;
      phase_r          <= PH_LINE1;
      line_count_r     <= '0;
      parsing_height_r <= 1'b0;
      image_width_r    <= '0;
      image_height_r   <= '0;
      limit_r          <= '0;
      chunk_row_base_r <= '0;
      row_in_chunk_r   <= '0;
      column_r         <= '0;
      byte_of_pixel_r  <= 2'd0;
      chunk_offset_r   <= '0;
      red_hold_r       <= '0;
      green_hold_r     <= '0;
      stride_r         <= p2r_pkg::STRIDE_RESET;
      out_valid_r      <= 1'b0;
      status_r         <= p2r_pkg::ST_WRITE;
      addr_r           <= '0;
      pix_r            <= '0;
    end else begin
      if (cfg_we) begin
        stride_r <= cfg_row_stride_bytes;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
        s1_byte_r  <= in_data_byte;
      end
      if (s1_go) begin
        phase_r          <= phase_nxt;
        line_count_r     <= line_count_nxt;
        parsing_height_r <= parsing_height_nxt;
        image_width_r    <= image_width_nxt;
        image_height_r   <= image_height_nxt;
        limit_r          <= limit_nxt;
        chunk_row_base_r <= chunk_row_base_nxt;
        row_in_chunk_r   <= row_in_chunk_nxt;
        column_r         <= column_nxt;
        byte_of_pixel_r  <= byte_of_pixel_nxt;
        chunk_offset_r   <= chunk_offset_nxt;
        red_hold_r       <= red_hold_nxt;
        green_hold_r     <= green_hold_nxt;
        if (emit) begin
          status_r <= status_nxt;
          addr_r   <= addr_nxt;
          pix_r    <= pix_nxt;
        end
      end
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire
